@@ hw/rtl/bmpc_pkg.sv @@
// Shared constants, types and helpers for the bitmap margin pad/crop block.
// No dependencies; compile first.
package bmpc_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_MARGIN = 255;

    localparam int DIM_W    = 13;                   // width/height register width
    localparam int CNT_W    = $clog2(MAX_DIM);      // row/column counter width
    localparam int MARGIN_W = 9;                    // signed margin register width
    localparam int SIDE_W   = MARGIN_W - 1;         // magnitude of one margin part
    localparam int PIX_W    = 8;
    localparam int PAD_W    = 21;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = DIM_W;

    typedef logic [DIM_W-1:0]           t_dim;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic signed [MARGIN_W-1:0] t_margin;
    typedef logic [SIDE_W-1:0]          t_side;
    typedef logic [PIX_W-1:0]           t_pix;
    typedef logic [PAD_W-1:0]           t_pad;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [DATA_W-1:0]          t_data;

    typedef enum logic [ADDR_W-1:0] {
        CFG_SRC_WIDTH     = 3'd0,
        CFG_SRC_HEIGHT    = 3'd1,
        CFG_LEFT_MARGIN   = 3'd2,
        CFG_RIGHT_MARGIN  = 3'd3,
        CFG_TOP_MARGIN    = 3'd4,
        CFG_BOTTOM_MARGIN = 3'd5
    } t_cfg_idx;

    // Saturate a dimension to 1..MAX_DIM.
    function automatic t_dim clamp_dim(input t_dim v);
        t_dim res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Saturate a margin to -MAX_MARGIN..MAX_MARGIN (signed compare throughout).
    function automatic t_margin clamp_margin(input t_margin v);
        t_margin res;
        if (v < t_margin'(-MAX_MARGIN)) begin
            res = t_margin'(-MAX_MARGIN);
        end else if (v > t_margin'(MAX_MARGIN)) begin
            res = t_margin'(MAX_MARGIN);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Positive part of a clamped margin (pad amount).
    function automatic t_side pad_part(input t_margin v);
        return v[MARGIN_W-1] ? '0 : v[SIDE_W-1:0];
    endfunction

    // Negative part of a clamped margin (crop amount).
    function automatic t_side crop_part(input t_margin v);
        t_margin neg;
        neg = -v;
        return v[MARGIN_W-1] ? neg[SIDE_W-1:0] : '0;
    endfunction

endpackage

@@ hw/rtl/bmpc_if.sv @@
// Valid/ready channel interfaces: source pixels, results and register writes.
// Depends on bmpc_pkg.
interface bmpc_pix_if;
    logic              valid;
    logic              ready;
    bmpc_pkg::t_pix    pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bmpc_res_if;
    logic              valid;
    logic              ready;
    bmpc_pkg::t_pad    pad_before;
    logic              keep;
    bmpc_pkg::t_pix    pixel_out;
    bmpc_pkg::t_pad    pad_after;
    logic              last;

    modport source (output valid, output pad_before, output keep, output pixel_out,
                    output pad_after, output last, input ready);
    modport sink   (input valid, input pad_before, input keep, input pixel_out,
                    input pad_after, input last, output ready);
endinterface

interface bmpc_cfg_if;
    logic              valid;
    logic              ready;
    bmpc_pkg::t_addr   addr;
    bmpc_pkg::t_data   data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/bitmap_margin_pad_crop.sv @@
// Bitmap margin pad/crop: top level, counters, geometry and result pipeline.
// Depends on bmpc_pkg and the channel interfaces in bmpc_if.sv.
//
// Usage:
//   i_pix carries the source bitmap one pixel a beat, in raster order.
//   o_res returns one beat per source pixel: the white run to emit before it,
//   whether it is copied (keep, pixel_out), the white run to emit after it,
//   and last on the final source pixel of the bitmap. Top and bottom padding
//   rows arrive folded into those runs.
//   i_cfg writes the six geometry registers (width, height, left, right, top,
//   bottom margin); it is always ready. Write it only while no pixel is in
//   flight. Row and column counters carry over a write.
// Timing:
//   An accepted pixel passes the input register, then the result register, on
//   its way to o_res (two-stage pipeline). One pixel per cycle is sustained
//   while o_res.ready stays high; the geometry (pad products, window bounds)
//   is refreshed from the registers every cycle, so it is in step with the
//   first pixel taken after a write.
// Reset:
//   Width and height return to 1, margins to 0, counters to zero, both pipe
//   stages empty. i_pix.ready stays low during reset and the cycle after it.
// Back-pressure:
//   With o_res.ready low the result register holds; the input register still
//   fills, and i_pix.ready drops only once both stages are occupied.
module bitmap_margin_pad_crop (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmpc_cfg_if.sink     i_cfg,
    bmpc_pix_if.sink     i_pix,
    bmpc_res_if.source   o_res
);
    import bmpc_pkg::*;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    t_dim    r_src_width, r_src_height;
    t_margin r_left, r_right, r_top, r_bottom;

    // ---------------------------------------------------------------------
    // Control and counters
    // ---------------------------------------------------------------------
    logic    r_run;          // registered high once reset is released; gates i_pix.ready
    t_cnt    r_row, r_col;   // position of the next source pixel
    t_cnt    n_row, n_col;

    // Input register (stage 1)
    logic    r_s1_valid;
    t_cnt    r_s1_row, r_s1_col;
    t_pix    r_s1_pix;
    logic    r_s1_last;

    // Result register (stage 2)
    logic    r_out_valid;
    t_pad    r_out_pad_before, r_out_pad_after;
    logic    r_out_keep;
    t_pix    r_out_pix;
    logic    r_out_last;

    // Geometry registers, refreshed every cycle
    logic    r_cw_pos, r_ch_pos;
    t_cnt    r_c0, r_c1, r_r0, r_r1;
    t_pad    r_top_block, r_bot_block;
    t_side   r_side_before;
    t_side   r_side_after_lo;   // pad right when the column window is open
    logic [SIDE_W:0] r_side_after;

    // ---------------------------------------------------------------------
    // Clamped geometry from the registers
    // ---------------------------------------------------------------------
    t_dim    w_cl, h_cl;
    t_margin lm, rm, tm, bm;
    t_side   padl, padr, padt, padb;
    t_side   cropl, cropr, cropt, cropb;
    logic signed [DIM_W+1:0] cw, ch;
    logic    cw_pos, ch_pos;
    t_dim    cw_mag;
    t_dim    dw;
    t_dim    w_m1, h_m1;
    t_dim    c1_open, r1_open;
    logic [DIM_W+SIDE_W-1:0] top_prod, bot_prod;

    always_comb begin
        w_cl  = clamp_dim(r_src_width);
        h_cl  = clamp_dim(r_src_height);
        lm    = clamp_margin(r_left);
        rm    = clamp_margin(r_right);
        tm    = clamp_margin(r_top);
        bm    = clamp_margin(r_bottom);
        padl  = pad_part(lm);
        padr  = pad_part(rm);
        padt  = pad_part(tm);
        padb  = pad_part(bm);
        cropl = crop_part(lm);
        cropr = crop_part(rm);
        cropt = crop_part(tm);
        cropb = crop_part(bm);

        cw = $signed({2'b00, w_cl}) - $signed({{(DIM_W+2-SIDE_W){1'b0}}, cropl})
           - $signed({{(DIM_W+2-SIDE_W){1'b0}}, cropr});
        ch = $signed({2'b00, h_cl}) - $signed({{(DIM_W+2-SIDE_W){1'b0}}, cropt})
           - $signed({{(DIM_W+2-SIDE_W){1'b0}}, cropb});
        cw_pos = !cw[DIM_W+1] && (cw != '0);
        ch_pos = !ch[DIM_W+1] && (ch != '0);
        cw_mag = cw_pos ? cw[DIM_W-1:0] : '0;

        // destination width: pads plus the open part of the window
        dw = cw_mag + DIM_W'(padl) + DIM_W'(padr);

        w_m1    = w_cl - DIM_W'(1);
        h_m1    = h_cl - DIM_W'(1);
        c1_open = w_m1 - DIM_W'(cropr);
        r1_open = h_m1 - DIM_W'(cropb);

        top_prod = (DIM_W+SIDE_W)'(padt) * (DIM_W+SIDE_W)'(dw);
        bot_prod = (DIM_W+SIDE_W)'(padb) * (DIM_W+SIDE_W)'(dw);
    end

    // ---------------------------------------------------------------------
    // Handshakes and counter advance
    // ---------------------------------------------------------------------
    logic w_in_acc, w_cfg_acc, w_s1_adv;
    logic w_row_end, w_last;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = r_run && (!r_s1_valid || w_s1_adv);
    assign w_in_acc    = i_pix.valid && i_pix.ready;

    always_comb begin
        w_row_end = {1'b0, r_col} >= w_m1;
        w_last    = w_row_end && ({1'b0, r_row} >= h_m1);
        if (w_last) begin
            n_row = '0;
            n_col = '0;
        end else if (w_row_end) begin
            n_row = r_row + CNT_W'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------------
    // Result logic: compare the registered position against window bounds
    // ---------------------------------------------------------------------
    logic w_row_in, w_col_in, w_keep;
    logic w_at_first, w_at_final;
    t_pad w_pb, w_pa;

    always_comb begin
        w_row_in   = r_ch_pos && (r_s1_row >= r_r0) && (r_s1_row <= r_r1);
        w_col_in   = r_cw_pos && (r_s1_col >= r_c0) && (r_s1_col <= r_c1);
        w_keep     = w_row_in && w_col_in;
        w_at_first = (r_s1_row == r_r0) && (r_s1_col == r_c0);
        w_at_final = (r_s1_row == r_r1) && (r_s1_col == r_c1);

        // top padding rows and the left pad ride in front of the window start
        w_pb = (w_at_first ? r_top_block : '0)
             + ((w_row_in && r_s1_col == r_c0) ? PAD_W'(r_side_before) : '0);
        // bottom padding rows and the right side ride behind the window end
        w_pa = (w_at_final ? r_bot_block : '0)
             + ((w_row_in && r_s1_col == r_c1) ? PAD_W'(r_side_after) : '0);
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_src_width  <= DIM_W'(1);
            r_src_height <= DIM_W'(1);
            r_left       <= '0;
            r_right      <= '0;
            r_top        <= '0;
            r_bottom     <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_run <= 1'b1;

            if (w_cfg_acc) begin
                case (t_cfg_idx'(i_cfg.addr))
                    CFG_SRC_WIDTH:     r_src_width  <= i_cfg.data;
                    CFG_SRC_HEIGHT:    r_src_height <= i_cfg.data;
                    CFG_LEFT_MARGIN:   r_left       <= t_margin'(i_cfg.data[MARGIN_W-1:0]);
                    CFG_RIGHT_MARGIN:  r_right      <= t_margin'(i_cfg.data[MARGIN_W-1:0]);
                    CFG_TOP_MARGIN:    r_top        <= t_margin'(i_cfg.data[MARGIN_W-1:0]);
                    CFG_BOTTOM_MARGIN: r_bottom     <= t_margin'(i_cfg.data[MARGIN_W-1:0]);
                    default: ;  // drop writes beyond the register list
                endcase
            end

            // advance the raster position on every accepted beat
            if (w_in_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end

            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // geometry: refresh every cycle
        r_cw_pos        <= cw_pos;
        r_ch_pos        <= ch_pos;
        r_c0            <= cw_pos ? CNT_W'(cropl) : '0;
        r_c1            <= cw_pos ? c1_open[CNT_W-1:0] : w_m1[CNT_W-1:0];
        r_r0            <= ch_pos ? CNT_W'(cropt) : '0;
        r_r1            <= ch_pos ? r1_open[CNT_W-1:0] : h_m1[CNT_W-1:0];
        r_top_block     <= top_prod[PAD_W-1:0];
        r_bot_block     <= bot_prod[PAD_W-1:0];
        r_side_before   <= cw_pos ? padl : '0;
        r_side_after_lo <= padr;
        r_side_after    <= cw_pos ? {1'b0, padr} : ({1'b0, padl} + {1'b0, padr});

        // stage 1 payload: hold until the next accepted beat
        if (w_in_acc) begin
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_pix  <= i_pix.pixel_in;
            r_s1_last <= w_last;
        end

        // result payload: hold while the receiver stalls
        if (w_s1_adv) begin
            r_out_pad_before <= w_pb;
            r_out_pad_after  <= w_pa;
            r_out_keep       <= w_keep;
            r_out_pix        <= w_keep ? r_s1_pix : '0;
            r_out_last       <= r_s1_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pad_before = r_out_pad_before;
    assign o_res.keep       = r_out_keep;
    assign o_res.pixel_out  = r_out_pix;
    assign o_res.pad_after  = r_out_pad_after;
    assign o_res.last       = r_out_last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // the final pixel of a bitmap returns the raster position to the origin
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> (r_row == '0 && r_col == '0))
        else $error("raster position not cleared after final pixel");

    // an accepted beat always lands in the input register
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted pixel lost before stage 1");

    // a kept pixel needs a non-empty window in both directions
    a_keep_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_keep) |-> (r_cw_pos && r_ch_pos))
        else $error("pixel kept with an empty copy window");

    // the side pad with an open column window is the right pad alone
    a_side_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && r_cw_pos) |-> (r_side_after == {1'b0, r_side_after_lo}))
        else $error("right-side pad mismatch");

endmodule
